// ===== hdl/yuv_rgb_color_converter_assert.svh =====
// Assertion macros used by the checker file of this block.
// Every macro samples on the rising clock edge and is switched off while
// the active-low reset is asserted.
`ifndef YUV_RGB_COLOR_CONVERTER_ASSERT_SVH
`define YUV_RGB_COLOR_CONVERTER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define YRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yrc assertion failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define YRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yrc assertion failed");

`endif

// ===== hdl/yrc_pkg.sv =====
package yrc_pkg;

    // Operation codes carried in the operation field.
    typedef enum logic {
        OP_YUV2RGB = 1'b0,
        OP_RGB2YUV = 1'b1
    } yrc_op_t;

    // Configuration register indexes.
    localparam int unsigned CfgIdxW  = 8;
    localparam int unsigned CfgDataW = 8;
    localparam logic [CfgIdxW-1:0] REG_SWAP_PIXEL_ORDER  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] REG_FORCE_GRAY_CHROMA = CfgIdxW'(1);

    // Truncating x*coef/1000 for 8-bit x is done as (x*M) >> RecipShift with
    // M = ceil(coef * 2^RecipShift / 1000). The rounding error of M stays
    // below 255/2^20, well under the 1/1000 step, so the result is exact.
    localparam int unsigned RecipShift = 20;
    localparam longint ScaleDen = 1000;
    localparam int unsigned MulW  = 21;
    localparam int unsigned ProdW = 8 + MulW;

    localparam logic [MulW-1:0] Mul299  =
        MulW'(((longint'(299)  << RecipShift) + ScaleDen - 1) / ScaleDen);
    localparam logic [MulW-1:0] Mul587  =
        MulW'(((longint'(587)  << RecipShift) + ScaleDen - 1) / ScaleDen);
    localparam logic [MulW-1:0] Mul114  =
        MulW'(((longint'(114)  << RecipShift) + ScaleDen - 1) / ScaleDen);
    localparam logic [MulW-1:0] Mul711  =
        MulW'(((longint'(711)  << RecipShift) + ScaleDen - 1) / ScaleDen);
    localparam logic [MulW-1:0] Mul560  =
        MulW'(((longint'(560)  << RecipShift) + ScaleDen - 1) / ScaleDen);
    localparam logic [MulW-1:0] Mul1402 =
        MulW'(((longint'(1402) << RecipShift) + ScaleDen - 1) / ScaleDen);
    localparam logic [MulW-1:0] Mul714  =
        MulW'(((longint'(714)  << RecipShift) + ScaleDen - 1) / ScaleDen);
    localparam logic [MulW-1:0] Mul344  =
        MulW'(((longint'(344)  << RecipShift) + ScaleDen - 1) / ScaleDen);
    localparam logic [MulW-1:0] Mul1772 =
        MulW'(((longint'(1772) << RecipShift) + ScaleDen - 1) / ScaleDen);

    localparam logic [7:0] ChromaOffset = 8'd128;
    localparam logic [7:0] GrayLevel    = 8'd128;

    // Signed chroma term, at most +-226 in magnitude.
    typedef logic signed [9:0] yrc_term_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] luma_first;
        logic [7:0] chroma_u;
        logic [7:0] luma_second;
        logic [7:0] chroma_v;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } yrc_in_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic [7:0] luma_out;
        logic [7:0] chroma_u_out;
        logic [7:0] chroma_v_out;
    } yrc_out_t;

    // Intermediate results held between the two arithmetic stages.
    typedef struct packed {
        logic       operation;
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        yrc_term_t  red_v;
        yrc_term_t  green_u;
        yrc_term_t  green_v;
        yrc_term_t  blue_u;
        logic [7:0] luma_calc;
        logic [7:0] red_711;
        logic [7:0] blue_560;
    } yrc_mid_t;

    // Configuration state seen by the output stage.
    typedef struct packed {
        logic swap_pixel_order;
        logic force_gray_chroma;
    } yrc_cfg_t;

    function automatic logic [8:0] scale_mag(input logic [7:0] x, input logic [MulW-1:0] mul);
        logic [ProdW-1:0] prod;
        prod = ProdW'(x) * ProdW'(mul);
        return prod[ProdW-1:RecipShift];
    endfunction

    // Distance of a chroma sample from 128, 0..128.
    function automatic logic [7:0] chroma_dist(input logic [7:0] c);
        logic [7:0] offset_mag;
        offset_mag = c[7] ? {1'b0, c[6:0]} : (ChromaOffset - c);
        return offset_mag;
    endfunction

    function automatic yrc_term_t apply_sign(input logic [8:0] mag, input logic neg);
        yrc_term_t t;
        t = signed'({1'b0, mag});
        return neg ? -t : t;
    endfunction

    function automatic logic [7:0] clip8(input logic signed [10:0] s);
        logic [7:0] c;
        if (s[10]) begin
            c = 8'd0;
        end else if (|s[9:8]) begin
            c = 8'd255;
        end else begin
            c = s[7:0];
        end
        return c;
    endfunction

endpackage

// ===== hdl/yrc_in_if.sv =====
interface yrc_in_if import yrc_pkg::*; ();
    logic    valid;
    logic    ready;
    yrc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/yrc_out_if.sv =====
interface yrc_out_if import yrc_pkg::*; ();
    logic     valid;
    logic     ready;
    yrc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/yrc_cfg_if.sv =====
interface yrc_cfg_if import yrc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/yuv_rgb_color_converter.sv =====
// Channel    | Modport | Payload                               | Transaction
// -----------+---------+---------------------------------------+------------------------
// cfg        | sink    | index, data (bit 0 is the new value)  | one register write
// pixel_in   | sink    | operation, YUYV macropixel or RGB     | one conversion request
// pixel_out  | source  | two RGB pixels and one YUV triple     | one conversion result
//
// One transaction enters per clock unless back-pressure holds the pipeline. Its result
// passes through the input register, the register after the first multiplier rank
// and the output register before it is offered on pixel_out.
// Reset (rst_n low, asynchronous) empties all stages and clears both settings.
// Back-pressure on pixel_out holds the output register and ripples back only
// through full stages, so up to three transactions wait while the output stalls.
module yuv_rgb_color_converter
    import yrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    yrc_cfg_if.sink      cfg,
    yrc_in_if.sink       pixel_in,
    yrc_out_if.source    pixel_out
);

    // Pipeline stage registers. Only the valid bits carry reset.
    logic     in_valid_reg;
    yrc_in_t  in_data_reg;
    logic     mid_valid_reg;
    yrc_mid_t mid_data_reg;
    logic     out_valid_reg;
    yrc_out_t out_data_reg;

    // Configuration registers and their next values.
    logic swap_reg;
    logic swap_next;
    logic gray_reg;
    logic gray_next;

    // Per-stage load enables: a stage may load when it is empty or when its
    // content moves on in the same cycle.
    logic out_load;
    logic mid_load;
    logic in_load;

    yrc_mid_t mid_calc;
    yrc_out_t out_calc;
    yrc_cfg_t cfg_state;

    assign out_load = !out_valid_reg || pixel_out.ready;
    assign mid_load = !mid_valid_reg || out_load;
    assign in_load  = !in_valid_reg || mid_load;

    assign pixel_in.ready  = in_load;
    assign pixel_out.valid = out_valid_reg;
    assign pixel_out.data  = out_data_reg;

    // Register writes are always taken; an unknown index changes nothing.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        swap_next = swap_reg;
        gray_next = gray_reg;
        if (cfg.valid) begin
            unique case (cfg.index)
                REG_SWAP_PIXEL_ORDER:  swap_next = cfg.data[0];
                REG_FORCE_GRAY_CHROMA: gray_next = cfg.data[0];
                default:               ;
            endcase
        end
    end

    assign cfg_state.swap_pixel_order  = swap_reg;
    assign cfg_state.force_gray_chroma = gray_reg;

    // First arithmetic stage: all products that depend on the inputs alone,
    // plus the luma sum of the RGB to YUV path.
    yrc_terms u_terms (
        .item (in_data_reg),
        .mid  (mid_calc)
    );

    // Second stage: products of the computed luma, sums, clipping, gray forcing,
    // pixel ordering and the per-mode selection of result fields.
    yrc_combine u_combine (
        .mid    (mid_data_reg),
        .cfg    (cfg_state),
        .result (out_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            swap_reg      <= 1'b0;
            gray_reg      <= 1'b0;
        end else begin
            swap_reg <= swap_next;
            gray_reg <= gray_next;
            if (in_load) begin
                in_valid_reg <= pixel_in.valid;
            end
            if (mid_load) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_load) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && pixel_in.valid) begin
            in_data_reg <= pixel_in.data;
        end
        if (mid_load && in_valid_reg) begin
            mid_data_reg <= mid_calc;
        end
        if (out_load && mid_valid_reg) begin
            out_data_reg <= out_calc;
        end
    end

endmodule

// ===== hdl/yrc_terms.sv =====
module yrc_terms
    import yrc_pkg::*;
(
    input  yrc_in_t  item,
    output yrc_mid_t mid
);

    logic [7:0] dist_u;
    logic [7:0] dist_v;
    logic [8:0] red_299;
    logic [8:0] green_587;
    logic [8:0] blue_114;
    logic [8:0] red_711;
    logic [8:0] blue_560;

    always_comb
    begin
        dist_u = chroma_dist(item.chroma_u);
        dist_v = chroma_dist(item.chroma_v);

        red_299   = scale_mag(item.red_in, Mul299);
        green_587 = scale_mag(item.green_in, Mul587);
        blue_114  = scale_mag(item.blue_in, Mul114);
        red_711   = scale_mag(item.red_in, Mul711);
        blue_560  = scale_mag(item.blue_in, Mul560);

        mid.operation   = item.operation;
        mid.luma_first  = item.luma_first;
        mid.luma_second = item.luma_second;
        // (V-128) and (U-128) are negative below 128; (128-U) and (128-V)
        // are negative above it. A zero distance gives zero either way.
        mid.red_v   = apply_sign(scale_mag(dist_v, Mul1402), !item.chroma_v[7]);
        mid.green_u = apply_sign(scale_mag(dist_u, Mul714), item.chroma_u[7]);
        mid.green_v = apply_sign(scale_mag(dist_v, Mul344), item.chroma_v[7]);
        mid.blue_u  = apply_sign(scale_mag(dist_u, Mul1772), !item.chroma_u[7]);
        mid.luma_calc = red_299[7:0] + green_587[7:0] + blue_114[7:0];
        mid.red_711   = red_711[7:0];
        mid.blue_560  = blue_560[7:0];
    end

endmodule

// ===== hdl/yrc_combine.sv =====
module yrc_combine
    import yrc_pkg::*;
(
    input  yrc_mid_t mid,
    input  yrc_cfg_t cfg,
    output yrc_out_t result
);

    logic [8:0]  y_711;
    logic [8:0]  y_560;
    logic [23:0] pix_a;
    logic [23:0] pix_b;

    function automatic logic [23:0] make_pixel(input logic [7:0] y, input yrc_mid_t m,
                                               input logic gray);
        logic signed [10:0] ys;
        logic signed [10:0] sr;
        logic signed [10:0] sg;
        logic signed [10:0] sb;
        logic [7:0]         g;
        logic [7:0]         b;
        ys = signed'({3'b000, y});
        sr = ys + {m.red_v[9], m.red_v};
        sg = ys + {m.green_u[9], m.green_u} + {m.green_v[9], m.green_v};
        sb = ys + {m.blue_u[9], m.blue_u};
        g  = gray ? GrayLevel : clip8(sg);
        b  = gray ? GrayLevel : clip8(sb);
        return {clip8(sr), g, b};
    endfunction

    always_comb
    begin
        y_711 = scale_mag(mid.luma_calc, Mul711);
        y_560 = scale_mag(mid.luma_calc, Mul560);
        pix_a = make_pixel(mid.luma_first, mid, cfg.force_gray_chroma);
        pix_b = make_pixel(mid.luma_second, mid, cfg.force_gray_chroma);

        result = '0;
        if (mid.operation == OP_RGB2YUV) begin
            result.luma_out     = mid.luma_calc;
            result.chroma_u_out = mid.blue_560 + ChromaOffset - y_560[7:0];
            result.chroma_v_out = mid.red_711 + ChromaOffset - y_711[7:0];
        end else if (cfg.swap_pixel_order) begin
            {result.red_first, result.green_first, result.blue_first}    = pix_b;
            {result.red_second, result.green_second, result.blue_second} = pix_a;
        end else begin
            {result.red_first, result.green_first, result.blue_first}    = pix_a;
            {result.red_second, result.green_second, result.blue_second} = pix_b;
        end
    end

endmodule

// ===== hdl/yrc_checker.sv =====
`include "yuv_rgb_color_converter_assert.svh"

module yrc_checker
    import yrc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input yrc_out_t out_data
);

    logic rgb_nonzero;
    logic yuv_zero;
    logic out_stalled;

    assign rgb_nonzero = |{out_data.red_first, out_data.green_first, out_data.blue_first,
                           out_data.red_second, out_data.green_second, out_data.blue_second};
    assign yuv_zero    = ~|{out_data.luma_out, out_data.chroma_u_out, out_data.chroma_v_out};
    assign out_stalled = out_valid && !out_ready;

    // A stalled result stays on the port unchanged.
    `YRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stalled, out_valid && $stable(out_data))

    // The input side only pushes back when the output itself is stalled.
    `YRC_ASSERT_NOW(a_ready_backpressure, clk, rst_n, !in_ready, out_stalled)

    // An RGB result never carries YUV fields, so the two modes do not mix.
    `YRC_ASSERT_NOW(a_mode_exclusive, clk, rst_n, out_valid && rgb_nonzero, yuv_zero)

endmodule

bind yuv_rgb_color_converter yrc_checker u_yrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixel_in.ready),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .out_data  (pixel_out.data)
);

// ===== test/yuv_rgb_color_converter_tb.sv =====
`timescale 1ns / 1ps

module yuv_rgb_color_converter_tb;
    import yrc_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung.
    // The slowest legitimate gap is the long output hold-off plus a few
    // random stalls, so this is many times that.
    localparam int unsigned HangLimit      = 2000;
    localparam int unsigned RandomPhases   = 6;
    localparam int unsigned PhaseItems     = 125;
    localparam int unsigned HoldOffAt      = 420;
    localparam int unsigned HoldOffCycles  = 64;
    localparam int unsigned IdlePercent    = 21;
    localparam int unsigned SettleCycles   = 8;

    // Scoreboard: keeps its own copy of the two configuration bits, predicts
    // the result of every accepted conversion request and checks each result
    // against the oldest prediction.
    class conversion_scoreboard;
        bit          swap_order;
        bit          gray_chroma;
        int unsigned errors;
        yrc_out_t    expected_results[$];

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void write_register(logic [CfgIdxW-1:0] index,
                                     logic [CfgDataW-1:0] value);
            // Only bit 0 carries the setting; other indexes are ignored.
            if (index == REG_SWAP_PIXEL_ORDER) begin
                swap_order = value[0];
            end else if (index == REG_FORCE_GRAY_CHROMA) begin
                gray_chroma = value[0];
            end
        endfunction

        // x*coef/1000 with truncation toward zero, as SV integer division does.
        function int scaled(int x, int coef);
            return (x * coef) / 1000;
        endfunction

        function logic [7:0] clamp_byte(int s);
            logic [7:0] c;
            if (s < 0) begin
                c = 8'd0;
            end else if (s > 255) begin
                c = 8'd255;
            end else begin
                c = 8'(s);
            end
            return c;
        endfunction

        function void convert_pixel(int luma, int u, int v,
                                    output logic [7:0] red,
                                    output logic [7:0] green,
                                    output logic [7:0] blue);
            red = clamp_byte(luma + scaled(v - 128, 1402));
            if (gray_chroma) begin
                green = 8'd128;
                blue  = 8'd128;
            end else begin
                green = clamp_byte(luma + scaled(128 - u, 714) + scaled(128 - v, 344));
                blue  = clamp_byte(luma + scaled(u - 128, 1772));
            end
        endfunction

        function yrc_out_t predict_conversion(yrc_in_t item);
            yrc_out_t   res;
            logic [7:0] r0, g0, b0, r1, g1, b1;
            logic [7:0] luma;
            res = '0;
            if (yrc_op_t'(item.operation) == OP_YUV2RGB) begin
                convert_pixel(item.luma_first, item.chroma_u, item.chroma_v, r0, g0, b0);
                convert_pixel(item.luma_second, item.chroma_u, item.chroma_v, r1, g1, b1);
                if (swap_order) begin
                    {res.red_first, res.green_first, res.blue_first} = {r1, g1, b1};
                    {res.red_second, res.green_second, res.blue_second} = {r0, g0, b0};
                end else begin
                    {res.red_first, res.green_first, res.blue_first} = {r0, g0, b0};
                    {res.red_second, res.green_second, res.blue_second} = {r1, g1, b1};
                end
            end else begin
                luma = 8'(scaled(item.red_in, 299) + scaled(item.green_in, 587)
                          + scaled(item.blue_in, 114));
                res.luma_out     = luma;
                res.chroma_v_out = 8'(scaled(item.red_in, 711) + 128 - scaled(luma, 711));
                res.chroma_u_out = 8'(scaled(item.blue_in, 560) + 128 - scaled(luma, 560));
            end
            return res;
        endfunction

        function void note_input(yrc_in_t item);
            expected_results.push_back(predict_conversion(item));
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 100) begin
                $display("MISMATCH at %0t: %s", $realtime, what);
            end
        endtask

        task check_result(yrc_out_t got);
            yrc_out_t want;
            string    field_names[9] = '{"red_first", "green_first", "blue_first",
                                         "red_second", "green_second", "blue_second",
                                         "luma_out", "chroma_u_out", "chroma_v_out"};
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %h with no request outstanding", got));
                return;
            end
            want = expected_results.pop_front();
            for (int i = 0; i < 9; i++) begin
                if (got[$bits(yrc_out_t)-1-8*i -: 8] !== want[$bits(yrc_out_t)-1-8*i -: 8]) begin
                    report_mismatch($sformatf("%s got %0d expected %0d", field_names[i],
                        got[$bits(yrc_out_t)-1-8*i -: 8],
                        want[$bits(yrc_out_t)-1-8*i -: 8]));
                end
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    yrc_cfg_if cfg_bus();
    yrc_in_if  pixel_in_bus();
    yrc_out_if pixel_out_bus();

    yuv_rgb_color_converter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .pixel_in  (pixel_in_bus),
        .pixel_out (pixel_out_bus)
    );

    conversion_scoreboard sb = new();

    // Flags steering the result sink. quiet_phase switches random idling off
    // on both sides for one whole phase; hold_output is the long stall that
    // lets the pipeline fill and push back on the input.
    bit          quiet_phase;
    bit          hold_output;
    int unsigned random_sent;
    int unsigned hung_cycles;

    initial begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Monitors. All three sample at the rising edge, where the handshake
    // takes effect; inputs are only changed on the falling edge.
    always @(posedge clk) begin
        if (rst_n && cfg_bus.valid && cfg_bus.ready) begin
            sb.write_register(cfg_bus.index, cfg_bus.data);
        end
    end

    always @(posedge clk) begin
        if (rst_n && pixel_in_bus.valid && pixel_in_bus.ready) begin
            sb.note_input(pixel_in_bus.data);
        end
    end

    always @(posedge clk) begin
        if (rst_n && pixel_out_bus.valid && pixel_out_bus.ready) begin
            sb.check_result(pixel_out_bus.data);
        end
    end

    // Watchdog: any transaction on any channel counts as progress.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cfg_bus.valid && cfg_bus.ready)
                || (pixel_in_bus.valid && pixel_in_bus.ready)
                || (pixel_out_bus.valid && pixel_out_bus.ready)) begin
                hung_cycles = 0;
            end else begin
                hung_cycles++;
                if (hung_cycles >= HangLimit) begin
                    $display("timeout: no transaction for %0d cycles", HangLimit);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // Result sink. Ready is redrawn every falling edge; unless a quiet phase is
    // running it drops with a chance of IdlePercent in a hundred, and it stays low
    // for the whole hold-off.
    initial begin
        pixel_out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            pixel_out_bus.ready = !hold_output
                && (quiet_phase || $urandom_range(99) >= IdlePercent);
        end
    end

    // Output hold-off in the middle of the random traffic. The sender keeps
    // offering requests, so the three stages fill and input ready must drop.
    initial begin
        hold_output = 1'b0;
        wait (random_sent == HoldOffAt);
        @(posedge clk);
        hold_output = 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        hold_output = 1'b0;
    end

    // One register write; returns on the falling edge after the transaction.
    task automatic write_reg(input logic [CfgIdxW-1:0] index,
                             input logic [CfgDataW-1:0] value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = index;
        cfg_bus.data  = value;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Writes both settings with junk in the unused upper data bits, then a
    // write to an index that has no register, which must change nothing.
    task automatic set_config(input bit swap, input bit gray);
        write_reg(REG_SWAP_PIXEL_ORDER, {7'($urandom), swap});
        write_reg(REG_FORCE_GRAY_CHROMA, {7'($urandom), gray});
        write_reg(CfgIdxW'($urandom_range(255, 2)), {7'($urandom), !gray});
    endtask

    // Offers one conversion request and returns right after the rising edge
    // that accepts it. Valid stays high so back-to-back requests need no gap.
    task automatic send_pixel(input yrc_in_t item);
        @(negedge clk);
        while (!quiet_phase && $urandom_range(99) < IdlePercent) begin
            pixel_in_bus.valid = 1'b0;
            @(negedge clk);
        end
        pixel_in_bus.valid = 1'b1;
        pixel_in_bus.data  = item;
        do @(posedge clk); while (!pixel_in_bus.ready);
    endtask

    // Drops valid and waits until every predicted result has been checked.
    // Every request yields exactly one result, so an empty queue means the
    // block is idle and registers may be written.
    task automatic drain_results();
        @(negedge clk);
        pixel_in_bus.valid = 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic yrc_in_t yuv_item(input logic [7:0] y0, input logic [7:0] u,
                                         input logic [7:0] y1, input logic [7:0] v);
        yrc_in_t item;
        item             = yrc_in_t'({$urandom, $urandom, $urandom});
        item.operation   = OP_YUV2RGB;
        item.luma_first  = y0;
        item.chroma_u    = u;
        item.luma_second = y1;
        item.chroma_v    = v;
        return item;
    endfunction

    function automatic yrc_in_t rgb_item(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        yrc_in_t item;
        item           = yrc_in_t'({$urandom, $urandom, $urandom});
        item.operation = OP_RGB2YUV;
        item.red_in    = r;
        item.green_in  = g;
        item.blue_in   = b;
        return item;
    endfunction

    // Mostly uniform bytes, with a bias toward the values around the clip
    // and chroma-offset boundaries.
    function automatic logic [7:0] random_byte();
        logic [7:0] b;
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(5))
                0:       b = 8'd0;
                1:       b = 8'd1;
                2:       b = 8'd127;
                3:       b = 8'd128;
                4:       b = 8'd254;
                default: b = 8'd255;
            endcase
        end else begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    // Directed corners. The fields not used by the chosen operation carry
    // random junk; the block must ignore them and zero the unused outputs.
    task automatic send_directed();
        send_pixel(yuv_item(8'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(yuv_item(8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(yuv_item(8'd0, 8'd128, 8'd255, 8'd128));
        send_pixel(yuv_item(8'd128, 8'd0, 8'd64, 8'd255));
        send_pixel(yuv_item(8'd16, 8'd255, 8'd235, 8'd0));
        send_pixel(yuv_item(8'd255, 8'd0, 8'd0, 8'd255));
        send_pixel(yuv_item(8'd1, 8'd127, 8'd254, 8'd129));
        send_pixel(rgb_item(8'd0, 8'd0, 8'd0));
        send_pixel(rgb_item(8'd255, 8'd255, 8'd255));
        send_pixel(rgb_item(8'd255, 8'd0, 8'd0));
        send_pixel(rgb_item(8'd0, 8'd255, 8'd0));
        send_pixel(rgb_item(8'd0, 8'd0, 8'd255));
    endtask

    initial begin
        bit      swap_plan[RandomPhases] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        bit      gray_plan[RandomPhases] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        yrc_in_t item;

        // Every block input is known from time zero.
        rst_n               = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        pixel_in_bus.valid  = 1'b0;
        pixel_in_bus.data   = '0;
        quiet_phase         = 1'b0;
        random_sent         = 0;
        hung_cycles         = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corners with the registers at their reset values, then again with
        // both set: swapped pixel order, gray chroma (no effect on RGB to YUV).
        send_directed();
        drain_results();
        set_config(1'b1, 1'b1);
        send_directed();
        drain_results();

        // Random traffic in phases, one register setting per phase. The second
        // phase runs with no idling on either side.
        for (int p = 0; p < RandomPhases; p++) begin
            set_config(swap_plan[p], gray_plan[p]);
            quiet_phase = (p == 1);
            for (int n = 0; n < PhaseItems; n++) begin
                if ($urandom_range(1) == 0) begin
                    item = yuv_item(random_byte(), random_byte(), random_byte(), random_byte());
                end else begin
                    item = rgb_item(random_byte(), random_byte(), random_byte());
                end
                send_pixel(item);
                random_sent++;
            end
            drain_results();
            quiet_phase = 1'b0;
        end

        // Give a stray extra result time to show up before the verdict.
        repeat (SettleCycles) @(posedge clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== yuv_rgb_color_converter.f =====
+incdir+hdl
hdl/yrc_pkg.sv
hdl/yrc_in_if.sv
hdl/yrc_out_if.sv
hdl/yrc_cfg_if.sv
hdl/yrc_terms.sv
hdl/yrc_combine.sv
hdl/yuv_rgb_color_converter.sv
hdl/yrc_checker.sv
test/yuv_rgb_color_converter_tb.sv
